// ===== src/lpm_route_table_assert.svh =====
// Assertion macros shared by the route table modules.
`ifndef LPM_ROUTE_TABLE_ASSERT_SVH
`define LPM_ROUTE_TABLE_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define LRT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("route table check failed");

// Check a consequence in the cycle after its antecedent.
`define LRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("route table check failed");

`endif

// ===== src/lrt_pkg.sv =====
// Shared types, constants and helpers for the route table.
`default_nettype none

package lrt_pkg;

   localparam int LRT_TABLE_DEPTH = 32;
   localparam int LRT_PORT_COUNT  = 8;

   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 3;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;
   localparam int CFG_W    = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } lrt_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } lrt_status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_WRITE,
      S_DONE
   } lrt_state_type;

   // One stored route; the whole word is one memory entry.
   typedef struct packed {
      logic              valid;
      logic              dynamic;
      logic [PORT_W-1:0] port;
      logic [ADDR_W-1:0] gateway;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] subnet;
   } lrt_entry_type;

   // Sequencer to match unit control.
   typedef struct packed {
      logic       start;
      logic       entry_vld;
      lrt_op_type op;
   } lrt_scan_ctl_type;

   // Match unit to sequencer status after a scan.
   typedef struct packed {
      logic found;
      logic diff;
      logic free_found;
   } lrt_scan_flags_type;

   // Route port is usable for lookup only when present and enabled.
   function automatic logic port_enabled(input logic [PORT_W-1:0] port,
                                         input logic [CFG_W-1:0] enable_mask);
      return (int'(port) < LRT_PORT_COUNT) && enable_mask[port];
   endfunction

endpackage

`default_nettype wire

// ===== src/lrt_route_mem.sv =====
// Route entry memory: one write port, one registered read port.
`default_nettype none

module lrt_route_mem #(
   parameter int TABLE_DEPTH = lrt_pkg::LRT_TABLE_DEPTH,
   localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [IDX_W-1:0]      wr_addr,
   input  wire lrt_pkg::lrt_entry_type wr_data,
   input  wire logic                  rd_en,
   input  wire logic [IDX_W-1:0]      rd_addr,
   output lrt_pkg::lrt_entry_type     rd_data
);

   lrt_pkg::lrt_entry_type route_mem_ff [TABLE_DEPTH];
   lrt_pkg::lrt_entry_type rd_data_ff;

   // Write one entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read one entry, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= route_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/lrt_match_unit.sv =====
// Shared compare unit: checks one entry a cycle and keeps the scan results.
`default_nettype none

`include "lpm_route_table_assert.svh"

module lrt_match_unit #(
   parameter int TABLE_DEPTH = lrt_pkg::LRT_TABLE_DEPTH,
   localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lrt_pkg::lrt_scan_ctl_type          scan_ctl,
   input  wire logic [IDX_W-1:0]                   entry_idx,
   input  wire lrt_pkg::lrt_entry_type             entry,
   input  wire logic [lrt_pkg::ADDR_W-1:0]         key,
   input  wire logic [lrt_pkg::ADDR_W-1:0]         req_mask,
   input  wire logic [lrt_pkg::ADDR_W-1:0]         req_gateway,
   input  wire logic [lrt_pkg::PORT_W-1:0]         req_port,
   input  wire logic                               req_dynamic,
   input  wire logic [lrt_pkg::CFG_W-1:0]          enable_mask,
   output lrt_pkg::lrt_scan_flags_type             flags,
   output logic [IDX_W-1:0]                        key_idx,
   output logic [IDX_W-1:0]                        free_idx,
   output logic [lrt_pkg::ADDR_W-1:0]              best_gateway,
   output logic [lrt_pkg::PORT_W-1:0]              best_port,
   output logic [lrt_pkg::ADDR_W-1:0]              best_mask,
   output logic [lrt_pkg::COUNT_W-1:0]             removed_count,
   output logic                                    clear_hit
);

   logic                          found_ff;
   logic                          diff_ff;
   logic                          free_found_ff;
   logic [lrt_pkg::COUNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]              key_idx_ff;
   logic [IDX_W-1:0]              free_idx_ff;
   logic [lrt_pkg::ADDR_W-1:0]    best_gateway_ff;
   logic [lrt_pkg::PORT_W-1:0]    best_port_ff;
   logic [lrt_pkg::ADDR_W-1:0]    best_mask_ff;

   logic [lrt_pkg::ADDR_W-1:0]    masked_addr;
   logic                          subnet_eq;
   logic                          mask_eq;
   logic                          mask_gt;
   logic                          port_ok;
   logic                          entry_diff;
   logic                          lookup_take;
   logic                          key_take;
   logic                          free_take;
   logic                          clear_take;

   // Compare the entry against the held request.
   always_comb begin
      masked_addr = (scan_ctl.op == lrt_pkg::OP_LOOKUP) ? (key & entry.mask) : key;
      subnet_eq   = (entry.subnet == masked_addr);
      mask_eq     = (entry.mask == req_mask);
      mask_gt     = (entry.mask > best_mask_ff);
      port_ok     = lrt_pkg::port_enabled(entry.port, enable_mask);
      entry_diff  = (entry.gateway != req_gateway) || (entry.port != req_port) ||
                    (entry.dynamic != req_dynamic);
      lookup_take = scan_ctl.entry_vld && (scan_ctl.op == lrt_pkg::OP_LOOKUP) &&
                    entry.valid && port_ok && subnet_eq && (!found_ff || mask_gt);
      key_take    = scan_ctl.entry_vld &&
                    ((scan_ctl.op == lrt_pkg::OP_INSERT) ||
                     (scan_ctl.op == lrt_pkg::OP_DELETE)) &&
                    entry.valid && subnet_eq && mask_eq && !found_ff;
      free_take   = scan_ctl.entry_vld && (scan_ctl.op == lrt_pkg::OP_INSERT) &&
                    !entry.valid && !free_found_ff;
      clear_take  = scan_ctl.entry_vld && (scan_ctl.op == lrt_pkg::OP_CLEAR) &&
                    entry.valid && entry.dynamic;
   end

   // Track found flags and the removal count; restart on each transaction.
   always_ff @(posedge clock) begin
      if (reset || scan_ctl.start) begin
         found_ff      <= 1'b0;
         diff_ff       <= 1'b0;
         free_found_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         if (lookup_take || key_take) begin
            found_ff <= 1'b1;
         end
         if (key_take) begin
            diff_ff <= entry_diff;
         end
         if (free_take) begin
            free_found_ff <= 1'b1;
         end
         if (clear_take && (count_ff != lrt_pkg::COUNT_MAX)) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // Hold the best route and the slots picked for a write.
   always_ff @(posedge clock) begin
      if (lookup_take) begin
         best_gateway_ff <= entry.gateway;
         best_port_ff    <= entry.port;
         best_mask_ff    <= entry.mask;
      end
      if (key_take) begin
         key_idx_ff <= entry_idx;
      end
      if (free_take) begin
         free_idx_ff <= entry_idx;
      end
   end

   assign flags.found      = found_ff;
   assign flags.diff       = diff_ff;
   assign flags.free_found = free_found_ff;
   assign key_idx          = key_idx_ff;
   assign free_idx         = free_idx_ff;
   assign best_gateway     = best_gateway_ff;
   assign best_port        = best_port_ff;
   assign best_mask        = best_mask_ff;
   assign removed_count    = count_ff;
   assign clear_hit        = clear_take;

   `LRT_ASSERT_NEXT(a_found_holds, clock, reset, found_ff && !scan_ctl.start, found_ff)
   `LRT_ASSERT_NEXT(a_free_holds, clock, reset, free_found_ff && !scan_ctl.start, free_found_ff)
   `LRT_ASSERT_NEXT(a_best_grows, clock, reset,
      found_ff && !scan_ctl.start && (scan_ctl.op == lrt_pkg::OP_LOOKUP),
      best_mask_ff >= $past(best_mask_ff))

endmodule

`default_nettype wire

// ===== src/lrt_sequencer.sv =====
// Sequencer: clearing pass, table scan, write back and result register.
`default_nettype none

`include "lpm_route_table_assert.svh"

module lrt_sequencer #(
   parameter int TABLE_DEPTH = lrt_pkg::LRT_TABLE_DEPTH,
   localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [lrt_pkg::OP_W-1:0]       req_op,
   input  wire logic [lrt_pkg::ADDR_W-1:0]     req_ip_addr,
   input  wire logic [lrt_pkg::ADDR_W-1:0]     req_prefix_mask,
   input  wire logic [lrt_pkg::ADDR_W-1:0]     req_next_hop,
   input  wire logic [lrt_pkg::PORT_W-1:0]     req_out_port,
   input  wire logic                           req_is_dynamic,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [lrt_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_changed,
   output logic [lrt_pkg::ADDR_W-1:0]          rsp_hit_gateway,
   output logic [lrt_pkg::PORT_W-1:0]          rsp_hit_port,
   output logic [lrt_pkg::ADDR_W-1:0]          rsp_hit_mask,
   output logic [lrt_pkg::COUNT_W-1:0]         rsp_removed_count,
   // memory
   output logic                                mem_wr_en,
   output logic [IDX_W-1:0]                    mem_wr_addr,
   output lrt_pkg::lrt_entry_type              mem_wr_data,
   output logic                                mem_rd_en,
   output logic [IDX_W-1:0]                    mem_rd_addr,
   // match unit
   output lrt_pkg::lrt_scan_ctl_type           scan_ctl,
   output logic [IDX_W-1:0]                    entry_idx,
   output logic [lrt_pkg::ADDR_W-1:0]          key,
   output logic [lrt_pkg::ADDR_W-1:0]          req_mask,
   output logic [lrt_pkg::ADDR_W-1:0]          req_gateway,
   output logic [lrt_pkg::PORT_W-1:0]          req_port,
   output logic                                req_dynamic,
   input  wire lrt_pkg::lrt_scan_flags_type    flags,
   input  wire logic [IDX_W-1:0]               key_idx,
   input  wire logic [IDX_W-1:0]               free_idx,
   input  wire logic [lrt_pkg::ADDR_W-1:0]     best_gateway,
   input  wire logic [lrt_pkg::PORT_W-1:0]     best_port,
   input  wire logic [lrt_pkg::ADDR_W-1:0]     best_mask,
   input  wire logic [lrt_pkg::COUNT_W-1:0]    removed_count,
   input  wire logic                           clear_hit
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   lrt_pkg::lrt_state_type          state_ff, state_in;
   logic [IDX_W-1:0]                addr_ff;
   logic                            issuing_ff;
   logic                            data_vld_ff;
   logic [IDX_W-1:0]                data_idx_ff;

   lrt_pkg::lrt_op_type             op_ff;
   logic [lrt_pkg::ADDR_W-1:0]      key_ff;
   logic [lrt_pkg::ADDR_W-1:0]      mask_ff;
   logic [lrt_pkg::ADDR_W-1:0]      gateway_ff;
   logic [lrt_pkg::PORT_W-1:0]      port_ff;
   logic                            dynamic_ff;

   logic                            rsp_valid_ff;
   logic [lrt_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                            rsp_changed_ff, rsp_changed_in;
   logic [lrt_pkg::ADDR_W-1:0]      rsp_gateway_ff, rsp_gateway_in;
   logic [lrt_pkg::PORT_W-1:0]      rsp_port_ff, rsp_port_in;
   logic [lrt_pkg::ADDR_W-1:0]      rsp_mask_ff, rsp_mask_in;
   logic [lrt_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                            req_take;
   logic                            rsp_take;
   logic                            rsp_load;
   logic                            addr_last;
   logic                            scan_last;
   lrt_pkg::lrt_entry_type          new_entry;

   assign req_take  = req_valid && (state_ff == lrt_pkg::S_IDLE);
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_load  = (state_ff == lrt_pkg::S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign addr_last = (addr_ff == LAST_IDX);
   assign scan_last = data_vld_ff && (data_idx_ff == LAST_IDX);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lrt_pkg::S_INIT: begin
            if (addr_last) state_in = lrt_pkg::S_IDLE;
         end
         lrt_pkg::S_IDLE: begin
            if (req_take) state_in = lrt_pkg::S_SCAN;
         end
         lrt_pkg::S_SCAN: begin
            if (scan_last) state_in = lrt_pkg::S_WRITE;
         end
         lrt_pkg::S_WRITE: begin
            state_in = lrt_pkg::S_DONE;
         end
         lrt_pkg::S_DONE: begin
            if (rsp_load) state_in = lrt_pkg::S_IDLE;
         end
         default: begin
            state_in = lrt_pkg::S_INIT;
         end
      endcase
   end

   // Memory controls per state.
   always_comb begin
      new_entry.valid   = 1'b1;
      new_entry.dynamic = dynamic_ff;
      new_entry.port    = port_ff;
      new_entry.gateway = gateway_ff;
      new_entry.mask    = mask_ff;
      new_entry.subnet  = key_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = addr_ff;

      unique case (state_ff)
         lrt_pkg::S_INIT: begin
            mem_wr_en = 1'b1;
         end
         lrt_pkg::S_SCAN: begin
            mem_rd_en   = issuing_ff;
            mem_wr_en   = clear_hit;
            mem_wr_addr = data_idx_ff;
         end
         lrt_pkg::S_WRITE: begin
            if (op_ff == lrt_pkg::OP_INSERT) begin
               mem_wr_data = new_entry;
               if (flags.found) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = key_idx;
               end else if (flags.free_found) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = free_idx;
               end
            end else if (op_ff == lrt_pkg::OP_DELETE) begin
               mem_wr_en   = flags.found;
               mem_wr_addr = key_idx;
            end
         end
         lrt_pkg::S_IDLE, lrt_pkg::S_DONE: begin
            mem_wr_en = 1'b0;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   // Result fields from the scan outcome.
   always_comb begin
      rsp_status_in  = lrt_pkg::STATUS_OK;
      rsp_changed_in = 1'b0;
      rsp_gateway_in = '0;
      rsp_port_in    = '0;
      rsp_mask_in    = '0;
      rsp_count_in   = '0;
      unique case (op_ff)
         lrt_pkg::OP_LOOKUP: begin
            if (flags.found) begin
               rsp_gateway_in = best_gateway;
               rsp_port_in    = best_port;
               rsp_mask_in    = best_mask;
            end else begin
               rsp_status_in = lrt_pkg::STATUS_MISS;
            end
         end
         lrt_pkg::OP_INSERT: begin
            if (flags.found) begin
               rsp_changed_in = flags.diff;
            end else if (flags.free_found) begin
               rsp_changed_in = 1'b1;
            end else begin
               rsp_status_in = lrt_pkg::STATUS_FULL;
            end
         end
         lrt_pkg::OP_DELETE: begin
            if (flags.found) begin
               rsp_changed_in = 1'b1;
            end else begin
               rsp_status_in = lrt_pkg::STATUS_MISS;
            end
         end
         lrt_pkg::OP_CLEAR: begin
            rsp_changed_in = (removed_count != '0);
            rsp_count_in   = removed_count;
         end
         default: begin
            rsp_status_in = lrt_pkg::STATUS_OK;
         end
      endcase
   end

   // Advance state, scan address and read pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lrt_pkg::S_INIT;
         addr_ff     <= '0;
         issuing_ff  <= 1'b0;
         data_vld_ff <= 1'b0;
         data_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         data_vld_ff <= (state_ff == lrt_pkg::S_SCAN) && issuing_ff;
         data_idx_ff <= addr_ff;
         if (req_take) begin
            addr_ff    <= '0;
            issuing_ff <= 1'b1;
         end else if ((state_ff == lrt_pkg::S_INIT) ||
                      ((state_ff == lrt_pkg::S_SCAN) && issuing_ff)) begin
            addr_ff <= addr_last ? '0 : addr_ff + 1'b1;
            if (addr_last) issuing_ff <= 1'b0;
         end
      end
   end

   // Capture the request transaction.
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff      <= lrt_pkg::lrt_op_type'(req_op);
         key_ff     <= (lrt_pkg::lrt_op_type'(req_op) == lrt_pkg::OP_INSERT) ?
                       (req_ip_addr & req_prefix_mask) : req_ip_addr;
         mask_ff    <= req_prefix_mask;
         gateway_ff <= req_next_hop;
         port_ff    <= req_out_port;
         dynamic_ff <= req_is_dynamic;
      end
   end

   // Hold the response transaction until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_changed_ff <= rsp_changed_in;
         rsp_gateway_ff <= rsp_gateway_in;
         rsp_port_ff    <= rsp_port_in;
         rsp_mask_ff    <= rsp_mask_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   assign req_stall         = (state_ff != lrt_pkg::S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_changed       = rsp_changed_ff;
   assign rsp_hit_gateway   = rsp_gateway_ff;
   assign rsp_hit_port      = rsp_port_ff;
   assign rsp_hit_mask      = rsp_mask_ff;
   assign rsp_removed_count = rsp_count_ff;

   assign scan_ctl.start     = req_take;
   assign scan_ctl.entry_vld = data_vld_ff;
   assign scan_ctl.op        = op_ff;
   assign entry_idx          = data_idx_ff;
   assign key                = key_ff;
   assign req_mask           = mask_ff;
   assign req_gateway        = gateway_ff;
   assign req_port           = port_ff;
   assign req_dynamic        = dynamic_ff;

   `LRT_ASSERT_NEXT(a_accept_scans, clock, reset, req_take, state_ff == lrt_pkg::S_SCAN)
   `LRT_ASSERT_SAME(a_idle_no_write, clock, reset,
      (state_ff == lrt_pkg::S_IDLE) || (state_ff == lrt_pkg::S_DONE), !mem_wr_en)
   `LRT_ASSERT_SAME(a_data_in_scan, clock, reset, data_vld_ff, state_ff == lrt_pkg::S_SCAN)

endmodule

`default_nettype wire

// ===== src/lpm_route_table.sv =====
// Top level of the longest-prefix-match route table.
//
//   channel  direction  handshake                 payload
//   req_     in         req_valid / req_stall     op, ip_addr, prefix_mask, next_hop,
//                                                 out_port, is_dynamic
//   rsp_     out        rsp_valid / rsp_stall     status, changed, hit_gateway,
//                                                 hit_port, hit_mask, removed_count
//   csr_     in         csr_wr_en                 wr_data (interface enable mask)
//
// Each transaction scans all TABLE_DEPTH entries, passes the write state and loads the
// result; the route memory read port delivers one entry per cycle to the single
// compare unit. After reset a clearing pass over all entries runs before the first
// accept; csr writes are taken throughout. One transaction is in work at a time; the
// next is accepted while the previous result still waits under rsp_stall.
`default_nettype none

module lpm_route_table #(
   parameter int TABLE_DEPTH = lrt_pkg::LRT_TABLE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [lrt_pkg::OP_W-1:0]      req_op,
   input  wire logic [lrt_pkg::ADDR_W-1:0]    req_ip_addr,
   input  wire logic [lrt_pkg::ADDR_W-1:0]    req_prefix_mask,
   input  wire logic [lrt_pkg::ADDR_W-1:0]    req_next_hop,
   input  wire logic [lrt_pkg::PORT_W-1:0]    req_out_port,
   input  wire logic                          req_is_dynamic,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [lrt_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_changed,
   output logic [lrt_pkg::ADDR_W-1:0]         rsp_hit_gateway,
   output logic [lrt_pkg::PORT_W-1:0]         rsp_hit_port,
   output logic [lrt_pkg::ADDR_W-1:0]         rsp_hit_mask,
   output logic [lrt_pkg::COUNT_W-1:0]        rsp_removed_count,
   input  wire logic                          csr_wr_en,
   input  wire logic [lrt_pkg::CFG_W-1:0]     csr_wr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [lrt_pkg::CFG_W-1:0]     enable_mask_ff;

   logic                          mem_wr_en;
   logic [IDX_W-1:0]              mem_wr_addr;
   lrt_pkg::lrt_entry_type        mem_wr_data;
   logic                          mem_rd_en;
   logic [IDX_W-1:0]              mem_rd_addr;
   lrt_pkg::lrt_entry_type        mem_rd_data;

   lrt_pkg::lrt_scan_ctl_type     scan_ctl;
   lrt_pkg::lrt_scan_flags_type   flags;
   logic [IDX_W-1:0]              entry_idx;
   logic [lrt_pkg::ADDR_W-1:0]    key;
   logic [lrt_pkg::ADDR_W-1:0]    req_mask;
   logic [lrt_pkg::ADDR_W-1:0]    req_gateway;
   logic [lrt_pkg::PORT_W-1:0]    req_port;
   logic                          req_dynamic;
   logic [IDX_W-1:0]              key_idx;
   logic [IDX_W-1:0]              free_idx;
   logic [lrt_pkg::ADDR_W-1:0]    best_gateway;
   logic [lrt_pkg::PORT_W-1:0]    best_port;
   logic [lrt_pkg::ADDR_W-1:0]    best_mask;
   logic [lrt_pkg::COUNT_W-1:0]   removed_count;
   logic                          clear_hit;

   // Interface enable register.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff <= '0;
      end else if (csr_wr_en) begin
         enable_mask_ff <= csr_wr_data;
      end
   end

   lrt_route_mem #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_route_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lrt_match_unit #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_match_unit (
      .clock         (clock),
      .reset         (reset),
      .scan_ctl      (scan_ctl),
      .entry_idx     (entry_idx),
      .entry         (mem_rd_data),
      .key           (key),
      .req_mask      (req_mask),
      .req_gateway   (req_gateway),
      .req_port      (req_port),
      .req_dynamic   (req_dynamic),
      .enable_mask   (enable_mask_ff),
      .flags         (flags),
      .key_idx       (key_idx),
      .free_idx      (free_idx),
      .best_gateway  (best_gateway),
      .best_port     (best_port),
      .best_mask     (best_mask),
      .removed_count (removed_count),
      .clear_hit     (clear_hit)
   );

   lrt_sequencer #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_sequencer (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_ip_addr       (req_ip_addr),
      .req_prefix_mask   (req_prefix_mask),
      .req_next_hop      (req_next_hop),
      .req_out_port      (req_out_port),
      .req_is_dynamic    (req_is_dynamic),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_changed       (rsp_changed),
      .rsp_hit_gateway   (rsp_hit_gateway),
      .rsp_hit_port      (rsp_hit_port),
      .rsp_hit_mask      (rsp_hit_mask),
      .rsp_removed_count (rsp_removed_count),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .scan_ctl          (scan_ctl),
      .entry_idx         (entry_idx),
      .key               (key),
      .req_mask          (req_mask),
      .req_gateway       (req_gateway),
      .req_port          (req_port),
      .req_dynamic       (req_dynamic),
      .flags             (flags),
      .key_idx           (key_idx),
      .free_idx          (free_idx),
      .best_gateway      (best_gateway),
      .best_port         (best_port),
      .best_mask         (best_mask),
      .removed_count     (removed_count),
      .clear_hit         (clear_hit)
   );

endmodule

`default_nettype wire
